FILE: hw/rtl/wcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcr_pkg
// Shared types and constants of the waveform column redraw unit: register
// indexes, word kinds, reset values and the configuration struct.
// ----------------------------------------------------------------------------
package wcr_pkg;

  // Default geometry of the row store.
  localparam int COLUMNS_DEFAULT  = 512;
  localparam int ROW_BITS_DEFAULT = 9;

  // Fixed field widths of the ports.
  localparam int COL_W       = 9;
  localparam int SAMPLE_W    = 12;
  localparam int PIX_W       = 9;
  localparam int GAIN_W      = 16;
  localparam int OFFSET_W    = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Gain is Q4.12, so the product drops this many fraction bits.
  localparam int GAIN_FRAC = 12;

  // Input word kinds.
  localparam logic KIND_SAMPLE     = 1'b0;
  localparam logic KIND_INVALIDATE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTRE_ROW      = 3'd0,
    REG_WINDOW_TOP      = 3'd1,
    REG_WINDOW_BOTTOM   = 3'd2,
    REG_ADC_MIDSCALE    = 3'd3,
    REG_VERTICAL_GAIN   = 3'd4,
    REG_VERTICAL_OFFSET = 3'd5
  } reg_index_t;

  // Register reset values.
  localparam logic [PIX_W-1:0]           CENTRE_ROW_RESET      = 9'd160;
  localparam logic [PIX_W-1:0]           WINDOW_TOP_RESET      = 9'd20;
  localparam logic [PIX_W-1:0]           WINDOW_BOTTOM_RESET   = 9'd299;
  localparam logic [SAMPLE_W-1:0]        ADC_MIDSCALE_RESET    = 12'd2048;
  localparam logic [GAIN_W-1:0]          VERTICAL_GAIN_RESET   = 16'd4096;
  localparam logic signed [OFFSET_W-1:0] VERTICAL_OFFSET_RESET = 10'sd0;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [PIX_W-1:0]           centre_row;
    logic [PIX_W-1:0]           window_top;
    logic [PIX_W-1:0]           window_bottom;
    logic [SAMPLE_W-1:0]        adc_midscale;
    logic [GAIN_W-1:0]          vertical_gain;
    logic signed [OFFSET_W-1:0] vertical_offset;
  } cfg_t;

endpackage

FILE: hw/rtl/wcr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcr_cfg_regs
// Configuration register file. Takes one write word per cycle and presents
// all registers as one struct to the datapath.
// ----------------------------------------------------------------------------
module wcr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wcr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wcr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output wcr_pkg::cfg_t                    cfg
);

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.centre_row      <= wcr_pkg::CENTRE_ROW_RESET;
      cfg.window_top      <= wcr_pkg::WINDOW_TOP_RESET;
      cfg.window_bottom   <= wcr_pkg::WINDOW_BOTTOM_RESET;
      cfg.adc_midscale    <= wcr_pkg::ADC_MIDSCALE_RESET;
      cfg.vertical_gain   <= wcr_pkg::VERTICAL_GAIN_RESET;
      cfg.vertical_offset <= wcr_pkg::VERTICAL_OFFSET_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        wcr_pkg::REG_CENTRE_ROW:      cfg.centre_row    <= cfg_data[wcr_pkg::PIX_W-1:0];
        wcr_pkg::REG_WINDOW_TOP:      cfg.window_top    <= cfg_data[wcr_pkg::PIX_W-1:0];
        wcr_pkg::REG_WINDOW_BOTTOM:   cfg.window_bottom <= cfg_data[wcr_pkg::PIX_W-1:0];
        wcr_pkg::REG_ADC_MIDSCALE:    cfg.adc_midscale  <= cfg_data[wcr_pkg::SAMPLE_W-1:0];
        wcr_pkg::REG_VERTICAL_GAIN:   cfg.vertical_gain <= cfg_data[wcr_pkg::GAIN_W-1:0];
        wcr_pkg::REG_VERTICAL_OFFSET: begin
          cfg.vertical_offset <= $signed(cfg_data[wcr_pkg::OFFSET_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/wcr_row_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcr_row_map
// Sample to pixel row mapping. The first register holds the magnitude of the
// offset from mid-scale, the second the scaled product; the clamp to the
// waveform window is combinational after the second register.
// ----------------------------------------------------------------------------
module wcr_row_map #(
  parameter int ROW_BITS = wcr_pkg::ROW_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          load_a,
  input  logic                          load_b,
  input  logic [wcr_pkg::SAMPLE_W-1:0]  sample,
  input  wcr_pkg::cfg_t                 cfg,
  output logic [ROW_BITS-1:0]           row
);

  localparam int SW   = wcr_pkg::SAMPLE_W;
  localparam int GW   = wcr_pkg::GAIN_W;
  localparam int PW   = wcr_pkg::PIX_W;
  localparam int PRW  = SW + GW;
  localparam int YW   = GW + 3;

  logic [SW:0]           diff;
  logic [SW:0]           mag_full;
  logic                  a_neg;
  logic [SW-1:0]         a_mag;
  logic [PRW-1:0]        product;
  logic                  b_neg;
  logic [GW-1:0]         b_scaled;
  logic signed [YW-1:0]  ext_centre;
  logic signed [YW-1:0]  ext_scaled;
  logic signed [YW-1:0]  ext_offset;
  logic signed [YW-1:0]  ext_top;
  logic signed [YW-1:0]  ext_bottom;
  logic signed [YW-1:0]  y;
  logic signed [YW-1:0]  y_top;
  logic signed [YW-1:0]  y_clamp;

  // Signed distance from mid-scale, split into sign and magnitude.
  assign diff     = {1'b0, sample} - {1'b0, cfg.adc_midscale};
  assign mag_full = diff[SW] ? ((SW + 1)'(0) - diff) : diff;

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_neg <= diff[SW];
      a_mag <= mag_full[SW-1:0];
    end
  end

  // Magnitude times Q4.12 gain, fraction dropped, so the value truncates toward zero.
  assign product = PRW'(a_mag) * PRW'(cfg.vertical_gain);

  always_ff @(posedge clk) begin
    if (load_b) begin
      b_neg    <= a_neg;
      b_scaled <= product[PRW-1:wcr_pkg::GAIN_FRAC];
    end
  end

  // Row before clamping: centre minus signed scaled value minus offset.
  assign ext_centre = $signed({(YW - PW)'(0), cfg.centre_row});
  assign ext_scaled = $signed({(YW - GW)'(0), b_scaled});
  assign ext_offset = YW'(cfg.vertical_offset);
  assign ext_top    = $signed({(YW - PW)'(0), cfg.window_top});
  assign ext_bottom = $signed({(YW - PW)'(0), cfg.window_bottom});

  always_comb begin
    if (b_neg) begin
      y = ext_centre + ext_scaled - ext_offset;
    end else begin
      y = ext_centre - ext_scaled - ext_offset;
    end
    // Top clamp first, then bottom, so a crossed window ends at the bottom.
    y_top   = (y < ext_top) ? ext_top : y;
    y_clamp = (y_top > ext_bottom) ? ext_bottom : y_top;
  end

  assign row = ROW_BITS'(y_clamp[PW-1:0]);

endmodule

FILE: hw/rtl/wcr_row_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcr_row_mem
// Row store of the previous frame: one synchronous read port with a
// registered output and one write port.
// ----------------------------------------------------------------------------
module wcr_row_mem #(
  parameter int DEPTH = wcr_pkg::COLUMNS_DEFAULT,
  parameter int WIDTH = wcr_pkg::ROW_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the output holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/waveform_column_redraw_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_column_redraw_unit
// Maps one sample per display column to a pixel row, compares it with the
// row of the previous frame and emits redraw words for changed columns.
// ----------------------------------------------------------------------------
// Path: an accepted word passes the first stage, the compare stage and the output
//   register. Throughput: one word per cycle unless the output stalls, set by
//   the single read and write port of the row memory, with the last write
//   forwarded to the compare stage.
// Reset: registers take their default values, the frame is marked invalid
//   and the left row is zero; the row memory is not cleared and needs no pass.
module waveform_column_redraw_unit #(
  parameter int COLUMNS  = wcr_pkg::COLUMNS_DEFAULT,
  parameter int ROW_BITS = wcr_pkg::ROW_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wcr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wcr_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input words.
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             kind,
  input  logic [wcr_pkg::COL_W-1:0]        column,
  input  logic [wcr_pkg::SAMPLE_W-1:0]     sample,
  // Redraw words.
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [wcr_pkg::COL_W-1:0]        draw_column,
  output logic [wcr_pkg::PIX_W-1:0]        segment_low,
  output logic [wcr_pkg::PIX_W-1:0]        segment_high
);

  localparam int CW  = wcr_pkg::COL_W;
  localparam int AW  = $clog2(COLUMNS);
  localparam logic [CW:0]   COL_LIMIT = (CW + 1)'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);

  wcr_pkg::cfg_t        cfg;

  // Pipeline control and column tags.
  logic                 in_fire;
  logic                 a_adv;
  logic                 b_ready;
  logic                 b_go;
  logic                 out_free;
  logic                 a_valid;
  logic                 a_kind;
  logic [CW-1:0]        a_col;
  logic                 b_valid;
  logic                 b_kind;
  logic [CW-1:0]        b_col;

  // Compare stage.
  logic [ROW_BITS-1:0]  b_row;
  logic [ROW_BITS-1:0]  mem_row;
  logic [ROW_BITS-1:0]  old_row;
  logic                 b_in_range;
  logic                 b_sample;
  logic                 here_changed;
  logic                 redraw;
  logic                 b_emit;
  logic [ROW_BITS-1:0]  lo;
  logic [ROW_BITS-1:0]  hi;

  // Last write to the row memory, for the read that overlaps it.
  logic                 fwd_valid;
  logic [AW-1:0]        fwd_addr;
  logic [ROW_BITS-1:0]  fwd_row;

  // Frame state.
  logic                 frame_valid;
  logic [ROW_BITS-1:0]  left_new_row;
  logic                 left_changed;

  wcr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wcr_row_map #(
    .ROW_BITS (ROW_BITS)
  ) u_map (
    .clk    (clk),
    .load_a (in_fire),
    .load_b (a_adv),
    .sample (sample),
    .cfg    (cfg),
    .row    (b_row)
  );

  // The old row is read as the word moves into the compare stage.
  wcr_row_mem #(
    .DEPTH (COLUMNS),
    .WIDTH (ROW_BITS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (a_adv),
    .rd_addr (a_col[AW-1:0]),
    .rd_data (mem_row),
    .wr_en   (b_go && b_sample),
    .wr_addr (b_col[AW-1:0]),
    .wr_data (b_row)
  );

  // Handshakes: each stage moves when the one after it has room.
  assign out_free = !out_valid || out_ready;
  assign b_go     = b_valid && (!b_emit || out_free);
  assign b_ready  = !b_valid || b_go;
  assign a_adv    = a_valid && b_ready;
  assign in_ready = !a_valid || b_ready;
  assign in_fire  = in_valid && in_ready;

  // Change detection and segment ends.
  always_comb begin
    b_in_range = ({1'b0, b_col} < COL_LIMIT);
    b_sample   = b_valid && (b_kind == wcr_pkg::KIND_SAMPLE) && b_in_range;
    if (fwd_valid && (fwd_addr == b_col[AW-1:0])) begin
      old_row = fwd_row;
    end else begin
      old_row = mem_row;
    end
    here_changed = !frame_valid || (b_row != old_row);
    if (b_col == CW'(0)) begin
      redraw = here_changed;
      lo     = b_row;
      hi     = b_row;
    end else begin
      redraw = here_changed || left_changed;
      lo     = (left_new_row < b_row) ? left_new_row : b_row;
      hi     = (left_new_row < b_row) ? b_row : left_new_row;
    end
    b_emit = b_sample && redraw;
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        b_valid <= 1'b1;
      end else if (b_go) begin
        b_valid <= 1'b0;
      end
    end
  end

  // Stage tags.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_kind <= kind;
      a_col  <= column;
    end
    if (a_adv) begin
      b_kind <= a_kind;
      b_col  <= a_col;
    end
  end

  // Frame state and the forwarded write, updated as a word leaves the compare stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid  <= 1'b0;
      left_new_row <= '0;
      left_changed <= 1'b0;
      fwd_valid    <= 1'b0;
    end else if (b_go) begin
      if (b_kind == wcr_pkg::KIND_INVALIDATE) begin
        frame_valid <= 1'b0;
      end else if (b_in_range) begin
        left_new_row <= b_row;
        left_changed <= here_changed;
        fwd_valid    <= 1'b1;
        if (b_col == COL_LAST) begin
          frame_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_sample) begin
      fwd_addr <= b_col[AW-1:0];
      fwd_row  <= b_row;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_go && b_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_emit) begin
      draw_column  <= b_col;
      segment_low  <= wcr_pkg::PIX_W'(lo);
      segment_high <= wcr_pkg::PIX_W'(hi);
    end
  end

endmodule

FILE: hw/rtl/wcr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcr_checker
// Port-level checks of the waveform column redraw unit, bound to the top.
// ----------------------------------------------------------------------------
module wcr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [wcr_pkg::COL_W-1:0]        draw_column,
  input logic [wcr_pkg::PIX_W-1:0]        segment_low,
  input logic [wcr_pkg::PIX_W-1:0]        segment_high
);

  // A stalled redraw word stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("redraw word dropped while stalled");

  // A stalled redraw word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(draw_column) && $stable(segment_low)
      && $stable(segment_high))
    else $error("redraw payload changed while stalled");

  // Segment ends come out ordered.
  a_seg_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> segment_low <= segment_high)
    else $error("segment ends out of order");

  // The first column draws a single point.
  a_first_point: assert property (@(posedge clk) disable iff (rst)
    out_valid && (draw_column == wcr_pkg::COL_W'(0)) |-> segment_low == segment_high)
    else $error("first column drew a segment");

  // Reset leaves no redraw word pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("redraw word valid after reset");

endmodule

bind waveform_column_redraw_unit wcr_checker u_wcr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .draw_column  (draw_column),
  .segment_low  (segment_low),
  .segment_high (segment_high)
);

FILE: bench/waveform_column_redraw_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_column_redraw_unit_test
// Self-checking bench for the waveform column redraw unit. A row predictor
// kept in step with every accepted word builds the expected redraw words.
// Directed corners come first, then whole and partial frames, register
// extremes and randomized phases with idling on both sides.
// ----------------------------------------------------------------------------
module waveform_column_redraw_unit_test;
  import wcr_pkg::*;

  localparam int NCOLS     = COLUMNS_DEFAULT;
  localparam int LAST_COL  = NCOLS - 1;
  localparam int WORD_GOAL = 1650;

  typedef struct {
    logic [COL_W-1:0] column;
    logic [PIX_W-1:0] low;
    logic [PIX_W-1:0] high;
  } redraw_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   kind = KIND_SAMPLE;
  logic [COL_W-1:0]       column = '0;
  logic [SAMPLE_W-1:0]    sample = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [COL_W-1:0]       draw_column;
  logic [PIX_W-1:0]       segment_low;
  logic [PIX_W-1:0]       segment_high;

  // Predictor state: live registers, last frame's rows and the left column.
  cfg_t                live_cfg;
  logic [PIX_W-1:0]    frame_rows [NCOLS];
  logic                frame_complete;
  logic [PIX_W-1:0]    left_row;
  logic                left_moved;
  redraw_t             pending_redraws [$];

  // Samples last sent per column, so that later frames can repeat them.
  logic [SAMPLE_W-1:0] trace_samples [NCOLS];

  int  words_sent       = 0;
  int  invalidates_sent = 0;
  int  redraws_checked  = 0;
  int  settings_applied = 0;
  int  mismatches       = 0;
  bit  quiet            = 1'b0;
  int  sink_hold        = 0;

  waveform_column_redraw_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .column       (column),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .draw_column  (draw_column),
    .segment_low  (segment_low),
    .segment_high (segment_high)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Gap length for either side: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sample to clamped pixel row; the scaled offset truncates toward zero.
  function automatic logic [PIX_W-1:0] row_of(logic [SAMPLE_W-1:0] s);
    int diff;
    int scaled;
    int y;
    diff   = int'(s) - int'(live_cfg.adc_midscale);
    scaled = ((diff < 0 ? -diff : diff) * int'(live_cfg.vertical_gain)) >>> GAIN_FRAC;
    if (diff < 0) scaled = -scaled;
    y = int'(live_cfg.centre_row) - scaled - int'($signed(live_cfg.vertical_offset));
    if (y < int'(live_cfg.window_top)) y = int'(live_cfg.window_top);
    if (y > int'(live_cfg.window_bottom)) y = int'(live_cfg.window_bottom);
    return PIX_W'(y);
  endfunction

  // Advance the predictor by one accepted word and queue any redraw.
  task automatic predict_redraw(input logic k, input logic [COL_W-1:0] c,
                                input logic [SAMPLE_W-1:0] s);
    logic [PIX_W-1:0] row;
    logic             moved;
    logic             redraw;
    redraw_t          cmd;
    if (k == KIND_INVALIDATE) begin
      frame_complete = 1'b0;
      return;
    end
    if (int'(c) >= NCOLS) return;
    row   = row_of(s);
    moved = !frame_complete || (row != frame_rows[c]);
    cmd.column = c;
    if (c == 0) begin
      redraw   = moved;
      cmd.low  = row;
      cmd.high = row;
    end else begin
      redraw   = moved || left_moved;
      cmd.low  = (left_row < row) ? left_row : row;
      cmd.high = (left_row < row) ? row : left_row;
    end
    frame_rows[c] = row;
    left_row      = row;
    left_moved    = moved;
    if (int'(c) == LAST_COL) frame_complete = 1'b1;
    if (redraw) pending_redraws.push_back(cmd);
  endtask

  // Send one word; called and returning at a falling edge.
  task automatic send_word(input logic k, input logic [COL_W-1:0] c,
                           input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    column   <= c;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
    predict_redraw(k, c, s);
    words_sent++;
    if (k == KIND_INVALIDATE) invalidates_sent++;
    @(negedge clk);
  endtask

  // Hold the input idle until every redraw is back and the pipe is empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_redraws.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // One register write; the predictor takes the value at acceptance.
  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CENTRE_ROW:      live_cfg.centre_row      = data[PIX_W-1:0];
      REG_WINDOW_TOP:      live_cfg.window_top      = data[PIX_W-1:0];
      REG_WINDOW_BOTTOM:   live_cfg.window_bottom   = data[PIX_W-1:0];
      REG_ADC_MIDSCALE:    live_cfg.adc_midscale    = data[SAMPLE_W-1:0];
      REG_VERTICAL_GAIN:   live_cfg.vertical_gain   = data[GAIN_W-1:0];
      REG_VERTICAL_OFFSET: live_cfg.vertical_offset = data[OFFSET_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Write all six registers while idle; unused upper data bits carry noise.
  task automatic apply_settings(input int centre, input int top, input int bottom,
                                input int mid, input int gain, input int offset);
    logic [CFG_DATA_W-1:0] data;
    wait_drained();
    data = CFG_DATA_W'($urandom);
    data[PIX_W-1:0] = PIX_W'(centre);
    write_reg(REG_CENTRE_ROW, data);
    data = CFG_DATA_W'($urandom);
    data[PIX_W-1:0] = PIX_W'(top);
    write_reg(REG_WINDOW_TOP, data);
    data = CFG_DATA_W'($urandom);
    data[PIX_W-1:0] = PIX_W'(bottom);
    write_reg(REG_WINDOW_BOTTOM, data);
    data = CFG_DATA_W'($urandom);
    data[SAMPLE_W-1:0] = SAMPLE_W'(mid);
    write_reg(REG_ADC_MIDSCALE, data);
    write_reg(REG_VERTICAL_GAIN, CFG_DATA_W'(gain));
    data = CFG_DATA_W'($urandom);
    data[OFFSET_W-1:0] = OFFSET_W'(offset);
    write_reg(REG_VERTICAL_OFFSET, data);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // New sample for a column: often a repeat of the last frame, so that unchanged
  // columns stay quiet, otherwise near midscale, at the rails or anywhere in range.
  function automatic logic [SAMPLE_W-1:0] vary_sample(int col);
    int pick;
    int level;
    pick = $urandom_range(0, 99);
    if (pick < 55) level = int'(trace_samples[col]);
    else if (pick < 75)
      level = int'(live_cfg.adc_midscale) + int'($urandom_range(0, 400)) - 200;
    else if (pick < 85) level = $urandom_range(0, 1) ? 4095 : 0;
    else level = $urandom_range(0, 4095);
    if (level < 0) level = 0;
    if (level > 4095) level = 4095;
    trace_samples[col] = SAMPLE_W'(level);
    return trace_samples[col];
  endfunction

  // Columns in order from start, with the odd invalidate or stray column.
  task automatic send_run(input int start, input int len);
    int c;
    int roll;
    for (c = start; c < start + len && c <= LAST_COL; c++) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) send_word(KIND_INVALIDATE, COL_W'($urandom), SAMPLE_W'($urandom));
      else if (roll < 5) begin
        roll = $urandom_range(0, LAST_COL);
        send_word(KIND_SAMPLE, COL_W'(roll), vary_sample(roll));
      end
      send_word(KIND_SAMPLE, COL_W'(c), vary_sample(c));
    end
  endtask

  // Corners at reset settings; column 511 is held back until a full frame
  // has written every row.
  task automatic test_directed_corners();
    send_word(KIND_SAMPLE, 9'd7, 12'd2100);        // left row is zero after reset
    send_word(KIND_SAMPLE, 9'd0, 12'd0);           // clamps to window bottom
    send_word(KIND_SAMPLE, 9'd1, 12'd4095);        // clamps to window top
    send_word(KIND_SAMPLE, 9'd2, 12'd2048);        // exactly midscale
    send_word(KIND_INVALIDATE, 9'd511, 12'd4095);
    send_word(KIND_SAMPLE, 9'd3, 12'd2047);
    send_word(KIND_SAMPLE, 9'd4, 12'd2049);
    send_word(KIND_SAMPLE, 9'd0, 12'h555);         // point after a higher column
    send_word(KIND_SAMPLE, 9'd256, 12'hAAA);
    send_word(KIND_SAMPLE, 9'd255, 12'h800);       // left neighbour not adjacent
    send_word(KIND_INVALIDATE, 9'd0, 12'd0);
    send_word(KIND_SAMPLE, 9'd510, 12'hFFF);
    send_word(KIND_SAMPLE, 9'd170, 12'h001);
    send_word(KIND_SAMPLE, 9'd341, 12'hFFE);
  endtask

  // A whole frame in column order; it marks the frame valid at the end.
  task automatic test_first_frame();
    int c;
    for (c = 0; c <= LAST_COL; c++) begin
      if ($urandom_range(0, 7) == 0)
        trace_samples[c] = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
      else
        trace_samples[c] = SAMPLE_W'(2048 + int'($urandom_range(0, 320)) - 160);
      send_word(KIND_SAMPLE, COL_W'(c), trace_samples[c]);
    end
  endtask

  // Repeat part of the frame with two edits, then force a redraw.
  task automatic test_repeat_frame();
    int c;
    for (c = 0; c < 96; c++) begin
      if (c == 40 || c == 70) trace_samples[c] = trace_samples[c] ^ 12'h0F0;
      send_word(KIND_SAMPLE, COL_W'(c), trace_samples[c]);
    end
    send_word(KIND_INVALIDATE, 9'd0, 12'd0);
    for (c = 0; c < 16; c++) send_word(KIND_SAMPLE, COL_W'(c), trace_samples[c]);
    wait_drained();
  endtask

  // Register extremes: all zero, all at their maximum, full gain with the most negative
  // offset, a crossed window and a small gain that exercises truncation.
  task automatic test_register_extremes();
    apply_settings(0, 0, 0, 0, 0, 0);
    send_run(0, 40);
    apply_settings(511, 511, 511, 4095, 65535, 511);
    send_run(0, 40);
    apply_settings(256, 0, 511, 2048, 65535, -512);
    send_run(0, 40);
    apply_settings(200, 400, 100, 1000, 8192, 37);
    send_run(0, 40);
    apply_settings(300, 5, 505, 2048, 1365, -1);
    send_run(0, 40);
  endtask

  // Random phases: each a new setting, then runs of columns, some of them
  // reaching the last column to complete a frame.
  task automatic test_random_frames();
    int phase_end;
    int top;
    int bottom;
    int swap;
    int roll;
    int start;
    while (words_sent < WORD_GOAL) begin
      top    = $urandom_range(0, 200);
      bottom = $urandom_range(250, 511);
      if ($urandom_range(0, 9) == 0) begin
        swap   = top;
        top    = bottom;
        bottom = swap;
      end
      apply_settings($urandom_range(0, 511), top, bottom, $urandom_range(0, 4095),
                     $urandom_range(0, 1) ? $urandom_range(0, 8192) : $urandom_range(0, 65535),
                     int'($urandom_range(0, 1023)) - 512);
      quiet     = ($urandom_range(0, 3) == 0);
      phase_end = words_sent + $urandom_range(120, 220);
      while (words_sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) send_run(0, $urandom_range(16, 128));
        else if (roll < 85) begin
          start = $urandom_range(420, LAST_COL);
          send_run(start, NCOLS - start);
        end else send_run($urandom_range(0, LAST_COL), $urandom_range(1, 24));
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
      quiet = 1'b0;
    end
  endtask

  // Receiver side: ready drops for random stretches.
  always @(negedge clk) begin : drive_out_ready
    if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      out_ready <= 1'b1;
      sink_hold = pick_gap();
    end
  end

  // Compare each accepted redraw word with the oldest expectation.
  always @(posedge clk) begin : check_redraws
    redraw_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_redraws.size() == 0) begin
        $error("Unexpected redraw word: draw_column %0d", draw_column);
        mismatches++;
      end else begin
        want = pending_redraws.pop_front();
        if (draw_column !== want.column) begin
          $error("draw_column: expected %0d, actual %0d", want.column, draw_column);
          mismatches++;
        end
        if (segment_low !== want.low) begin
          $error("segment_low: expected %0d, actual %0d", want.low, segment_low);
          mismatches++;
        end
        if (segment_high !== want.high) begin
          $error("segment_high: expected %0d, actual %0d", want.high, segment_high);
          mismatches++;
        end
        redraws_checked++;
      end
    end
  end

  // Main sequence.
  initial begin
    live_cfg.centre_row      = CENTRE_ROW_RESET;
    live_cfg.window_top      = WINDOW_TOP_RESET;
    live_cfg.window_bottom   = WINDOW_BOTTOM_RESET;
    live_cfg.adc_midscale    = ADC_MIDSCALE_RESET;
    live_cfg.vertical_gain   = VERTICAL_GAIN_RESET;
    live_cfg.vertical_offset = VERTICAL_OFFSET_RESET;
    frame_complete = 1'b0;
    left_row       = '0;
    left_moved     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_corners();
    test_first_frame();
    test_repeat_frame();
    test_register_extremes();
    test_random_frames();
    wait_drained();
    repeat (10) @(negedge clk);

    $display("Run covered %0d words (%0d invalidates) under %0d register settings,",
             words_sent, invalidates_sent, settings_applied);
    $display("with %0d redraw words compared field by field.", redraws_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Timeout with %0d redraw words outstanding", pending_redraws.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: waveform_column_redraw_unit.f
hw/rtl/wcr_pkg.sv
hw/rtl/wcr_cfg_regs.sv
hw/rtl/wcr_row_map.sv
hw/rtl/wcr_row_mem.sv
hw/rtl/waveform_column_redraw_unit.sv
hw/rtl/wcr_checker.sv
bench/waveform_column_redraw_unit_test.sv
